// File: src/tbq_pkg.sv
// ----------------------------------------------------------------------------
// tbq_pkg
// Shared widths, register codes and types of the three-axis biquad low-pass.
// ----------------------------------------------------------------------------
package tbq_pkg;

  localparam int AXIS_COUNT   = 3;
  localparam int SAMPLE_WIDTH = 32;
  localparam int COEF_WIDTH   = 32;

  localparam int REG_COUNT  = 5;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int FRAC_SHIFT = COEF_WIDTH - 2;
  localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_EXT    = 3;
  localparam int ACC_W      = PROD_W + ACC_EXT;
  localparam int SHIFT_W    = ACC_W - FRAC_SHIFT;
  localparam int DATA_W     = ((AXIS_COUNT * SAMPLE_WIDTH + 7) / 8) * 8;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_B0 = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_B1 = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_B2 = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_A1 = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_A2 = REG_IDX_W'(4);

  // operation codes
  localparam logic OP_FILTER  = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  // sequencer steps of a lane
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_B0   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_B1   = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_B2   = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_A1   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_A2   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_ACC  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(6);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef coef_t   [REG_COUNT-1:0]        coef_set_t;
  typedef sample_t [AXIS_COUNT-1:0]       sample_arr_t;

  // 30 Hz Butterworth at 500 Hz
  localparam coef_t COEF_B0_RST = coef_t'(32'sd29914200);
  localparam coef_t COEF_B1_RST = coef_t'(32'sd59828390);
  localparam coef_t COEF_B2_RST = coef_t'(32'sd29914200);
  localparam coef_t COEF_A1_RST = coef_t'(-32'sd1584285059);
  localparam coef_t COEF_A2_RST = coef_t'(32'sd630200025);

  typedef struct packed {
    logic               run;
    logic [STEP_W-1:0]  step;
    logic               start;
    logic               commit;
    logic               preload;
  } lane_ctrl_t;

endpackage

// File: src/tbq_lane.sv
// ----------------------------------------------------------------------------
// tbq_lane
// One axis: history taps and a shared multiplier stepping through five taps.
// ----------------------------------------------------------------------------
module tbq_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  tbq_pkg::lane_ctrl_t ctrl,
  input  tbq_pkg::sample_t    sample,
  input  tbq_pkg::coef_set_t  coefs,
  output tbq_pkg::sample_t    result
);

  localparam logic [tbq_pkg::ACC_W-1:0] ROUND_ADD =
    tbq_pkg::ACC_W'(1) << (tbq_pkg::FRAC_SHIFT - 1);

  tbq_pkg::sample_t x_r, x1_r, x2_r, y1_r, y2_r;
  tbq_pkg::sample_t opnd;
  tbq_pkg::coef_t   cf;

  logic signed [tbq_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                              sub_r, sub_nxt;
  logic signed [tbq_pkg::ACC_W-1:0]  acc_r, acc_nxt, term;
  logic [tbq_pkg::ACC_W-1:0]         rnd;
  logic [tbq_pkg::SHIFT_W-1:0]       shifted;
  logic [tbq_pkg::SHIFT_W-tbq_pkg::SAMPLE_WIDTH:0] upper;

  always_comb begin
    unique case (ctrl.step)
      tbq_pkg::STEP_B0: begin opnd = x_r;  cf = coefs[tbq_pkg::REG_B0]; end
      tbq_pkg::STEP_B1: begin opnd = x1_r; cf = coefs[tbq_pkg::REG_B1]; end
      tbq_pkg::STEP_B2: begin opnd = x2_r; cf = coefs[tbq_pkg::REG_B2]; end
      tbq_pkg::STEP_A1: begin opnd = y1_r; cf = coefs[tbq_pkg::REG_A1]; end
      tbq_pkg::STEP_A2: begin opnd = y2_r; cf = coefs[tbq_pkg::REG_A2]; end
      default:          begin opnd = x_r;  cf = coefs[tbq_pkg::REG_B0]; end
    endcase
    prod_nxt = $signed(opnd) * $signed(cf);
    sub_nxt  = (ctrl.step == tbq_pkg::STEP_A1) || (ctrl.step == tbq_pkg::STEP_A2);
  end

  always_comb begin
    term = {{tbq_pkg::ACC_EXT{prod_r[tbq_pkg::PROD_W-1]}}, prod_r};
    if (sub_r) begin
      term = -term;
    end
    if (ctrl.step == tbq_pkg::STEP_B0) begin
      acc_nxt = '0;
    end else if (ctrl.step == tbq_pkg::STEP_DONE) begin
      acc_nxt = acc_r;
    end else begin
      acc_nxt = acc_r + term;
    end
  end

  // round half up, drop fraction, saturate
  always_comb begin
    rnd     = acc_r + ROUND_ADD;
    shifted = rnd[tbq_pkg::ACC_W-1:tbq_pkg::FRAC_SHIFT];
    upper   = shifted[tbq_pkg::SHIFT_W-1:tbq_pkg::SAMPLE_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      result = shifted[tbq_pkg::SAMPLE_WIDTH-1:0];
    end else if (shifted[tbq_pkg::SHIFT_W-1]) begin
      result = {1'b1, {(tbq_pkg::SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      result = {1'b0, {(tbq_pkg::SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x_r <= sample;
    end
    if (ctrl.run) begin
      prod_r <= prod_nxt;
      sub_r  <= sub_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (ctrl.preload) begin
      x1_r <= sample;
      x2_r <= sample;
      y1_r <= sample;
      y2_r <= sample;
    end else if (ctrl.commit) begin
      x1_r <= x_r;
      x2_r <= x1_r;
      y1_r <= result;
      y2_r <= y1_r;
    end
  end

endmodule

// File: src/tbq_merge.sv
// ----------------------------------------------------------------------------
// tbq_merge
// Gathers the lane results into one output transfer and holds it until taken.
// ----------------------------------------------------------------------------
module tbq_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        commit,
  input  tbq_pkg::sample_arr_t        results,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [tbq_pkg::DATA_W-1:0]  out_tdata,
  output logic                        slot_free
);

  logic                       valid_r, valid_nxt;
  logic [tbq_pkg::DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    data_nxt = '0;
    for (int a = 0; a < tbq_pkg::AXIS_COUNT; a++) begin
      data_nxt[a*tbq_pkg::SAMPLE_WIDTH +: tbq_pkg::SAMPLE_WIDTH] = results[a];
    end
    slot_free = !valid_r || out_tready;
    valid_nxt = commit || (valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// File: src/three_axis_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass
// Direct form I biquad low-pass on three axes with one shared coefficient set.
//
//   channel | ports                       | content
//   --------+-----------------------------+--------------------------------
//   in      | in_tvalid/tready/tdata/tuser| samples x,y,z; tuser = operation
//   out     | out_tvalid/tready/tdata     | filtered x,y,z
//   cfg     | cfg_valid/ready/index/data  | coef_b0 b1 b2 a1 a2, always ready
//
// After a filter item leaves the input buffer, each lane's single
// multiplier walks the five taps, then a sum step adds the last product
// and a done step rounds, saturates and updates history once output is free.
// The input buffer takes the next transfer while a lane computes, and the
// output register holds a result while the next item is worked on.
// Reset (synchronous, rst_n low) zeroes history and loads the default set.
// ----------------------------------------------------------------------------
module three_axis_biquad_lowpass (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tbq_pkg::DATA_W-1:0]         in_tdata,   // sample_x, sample_y, sample_z
  input  logic                               in_tuser,   // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tbq_pkg::DATA_W-1:0]         out_tdata,  // filtered_x, filtered_y, filtered_z
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbq_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [tbq_pkg::COEF_WIDTH-1:0]     cfg_data
);

  tbq_pkg::coef_set_t   coef_r;
  tbq_pkg::sample_arr_t buf_samp_r;
  tbq_pkg::sample_arr_t results;
  logic                 buf_valid_r, buf_valid_nxt;
  logic                 buf_op_r;
  logic                 busy_r, busy_nxt;
  logic [tbq_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                 in_xfer, start, commit, slot_free;
  tbq_pkg::lane_ctrl_t  ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[tbq_pkg::REG_B0] <= tbq_pkg::COEF_B0_RST;
      coef_r[tbq_pkg::REG_B1] <= tbq_pkg::COEF_B1_RST;
      coef_r[tbq_pkg::REG_B2] <= tbq_pkg::COEF_B2_RST;
      coef_r[tbq_pkg::REG_A1] <= tbq_pkg::COEF_A1_RST;
      coef_r[tbq_pkg::REG_A2] <= tbq_pkg::COEF_A2_RST;
    end else if (cfg_valid && (cfg_index < tbq_pkg::REG_IDX_W'(tbq_pkg::REG_COUNT))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    start     = buf_valid_r && !busy_r;
    in_tready = !buf_valid_r || start;
    in_xfer   = in_tvalid && in_tready;
    commit    = busy_r && (cnt_r == tbq_pkg::STEP_DONE) && slot_free;

    buf_valid_nxt = in_xfer || (buf_valid_r && !start);

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start && (buf_op_r == tbq_pkg::OP_FILTER)) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tbq_pkg::STEP_B0;
    end else if (commit) begin
      busy_nxt = 1'b0;
      cnt_nxt  = tbq_pkg::STEP_B0;
    end else if (busy_r && (cnt_r != tbq_pkg::STEP_DONE)) begin
      cnt_nxt = cnt_r + tbq_pkg::STEP_W'(1);
    end

    ctrl.run     = busy_r;
    ctrl.step    = cnt_r;
    ctrl.start   = start && (buf_op_r == tbq_pkg::OP_FILTER);
    ctrl.commit  = commit;
    ctrl.preload = start && (buf_op_r == tbq_pkg::OP_PRELOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      cnt_r       <= tbq_pkg::STEP_B0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      buf_op_r <= in_tuser;
      for (int a = 0; a < tbq_pkg::AXIS_COUNT; a++) begin
        buf_samp_r[a] <= in_tdata[a*tbq_pkg::SAMPLE_WIDTH +: tbq_pkg::SAMPLE_WIDTH];
      end
    end
  end

  for (genvar g = 0; g < tbq_pkg::AXIS_COUNT; g++) begin : g_lane
    tbq_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .sample (buf_samp_r[g]),
      .coefs  (coef_r),
      .result (results[g])
    );
  end

  tbq_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .results    (results),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .slot_free  (slot_free)
  );

  a_step_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cnt_r != tbq_pkg::STEP_DONE)) |=>
      (busy_r && (cnt_r == $past(cnt_r) + tbq_pkg::STEP_W'(1))))
    else $error("lane sequencer did not advance");

  a_commit_shows : assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid)
    else $error("committed result not presented");

  a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r |-> (cnt_r <= tbq_pkg::STEP_DONE)) and
    (!busy_r |-> (cnt_r == tbq_pkg::STEP_B0)))
    else $error("sequencer step out of range");

endmodule

// File: test/three_axis_biquad_lowpass_tb.sv
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass_tb
// Self-checking bench for the three-axis biquad low-pass. Items and
// coefficient writes go through the stream and config ports. A scoreboard
// keeps its own copy of coefficients and tap history, predicts every filtered
// triple in wide signed arithmetic and compares each output transfer axis by
// axis. Directed steps and preloads come first, then random items under
// several coefficient sets, extremes included, with random stalls on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module three_axis_biquad_lowpass_tb;

  typedef logic signed [127:0] wide_t;
  typedef enum {SET_DEFAULT, SET_TOP, SET_BOTTOM, SET_UNITY, SET_NEAR, SET_WILD} coef_kind_t;

  localparam tbq_pkg::sample_t SAMPLE_TOP    = {1'b0, {(tbq_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam tbq_pkg::sample_t SAMPLE_BOTTOM = {1'b1, {(tbq_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam tbq_pkg::coef_t   COEF_TOP      = {1'b0, {(tbq_pkg::COEF_WIDTH-1){1'b1}}};
  localparam tbq_pkg::coef_t   COEF_BOTTOM   = {1'b1, {(tbq_pkg::COEF_WIDTH-1){1'b0}}};
  localparam int               ITEMS_PER_SET = 176;
  localparam int               HOLD_CYCLES   = 400;
  localparam int               HOLD_AFTER    = 600;

  class biquad_scoreboard;
    tbq_pkg::coef_t       coef [tbq_pkg::REG_COUNT];
    tbq_pkg::sample_t     in_hist [tbq_pkg::AXIS_COUNT][2];
    tbq_pkg::sample_t     out_hist [tbq_pkg::AXIS_COUNT][2];
    tbq_pkg::sample_arr_t filtered_q [$];
    int                   errors;
    string                field_name [tbq_pkg::AXIS_COUNT] =
      '{"filtered_x", "filtered_y", "filtered_z"};

    function void clear();
      coef[tbq_pkg::REG_B0] = tbq_pkg::COEF_B0_RST;
      coef[tbq_pkg::REG_B1] = tbq_pkg::COEF_B1_RST;
      coef[tbq_pkg::REG_B2] = tbq_pkg::COEF_B2_RST;
      coef[tbq_pkg::REG_A1] = tbq_pkg::COEF_A1_RST;
      coef[tbq_pkg::REG_A2] = tbq_pkg::COEF_A2_RST;
      foreach (in_hist[a, t]) begin
        in_hist[a][t]  = '0;
        out_hist[a][t] = '0;
      end
      filtered_q.delete();
      errors = 0;
    endfunction

    function void set_coef(logic [tbq_pkg::REG_IDX_W-1:0] idx, tbq_pkg::coef_t value);
      if (idx < tbq_pkg::REG_COUNT) coef[idx] = value;
    endfunction

    function wide_t prod(wide_t v, wide_t c);
      return v * c;
    endfunction

    function tbq_pkg::sample_t run_axis(int a, tbq_pkg::sample_t x);
      wide_t            acc;
      tbq_pkg::sample_t y;
      acc = prod(x, coef[tbq_pkg::REG_B0]) + prod(in_hist[a][0], coef[tbq_pkg::REG_B1])
          + prod(in_hist[a][1], coef[tbq_pkg::REG_B2])
          - prod(out_hist[a][0], coef[tbq_pkg::REG_A1])
          - prod(out_hist[a][1], coef[tbq_pkg::REG_A2]);
      // round half up, then back to Q16.16
      acc = (acc + (wide_t'(1) <<< (tbq_pkg::FRAC_SHIFT - 1))) >>> tbq_pkg::FRAC_SHIFT;
      if (acc > SAMPLE_TOP) y = SAMPLE_TOP;
      else if (acc < SAMPLE_BOTTOM) y = SAMPLE_BOTTOM;
      else y = tbq_pkg::sample_t'(acc);
      in_hist[a][1]  = in_hist[a][0];
      in_hist[a][0]  = x;
      out_hist[a][1] = out_hist[a][0];
      out_hist[a][0] = y;
      return y;
    endfunction

    function void note_input(logic op, tbq_pkg::sample_arr_t s);
      tbq_pkg::sample_arr_t r;
      if (op == tbq_pkg::OP_PRELOAD) begin
        for (int a = 0; a < tbq_pkg::AXIS_COUNT; a++) begin
          in_hist[a][0]  = s[a];
          in_hist[a][1]  = s[a];
          out_hist[a][0] = s[a];
          out_hist[a][1] = s[a];
        end
      end else begin
        for (int a = 0; a < tbq_pkg::AXIS_COUNT; a++) r[a] = run_axis(a, s[a]);
        filtered_q.push_back(r);
      end
    endfunction

    function void check_result(tbq_pkg::sample_arr_t got);
      tbq_pkg::sample_arr_t want;
      if (filtered_q.size() == 0) begin
        $error("output transfer with no result pending: %h", got);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      for (int a = 0; a < tbq_pkg::AXIS_COUNT; a++) begin
        if (got[a] !== want[a]) begin
          $error("%s: expected %0d, got %0d", field_name[a], want[a], got[a]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tbq_pkg::DATA_W-1:0]     in_tdata;   // sample_x, sample_y, sample_z
  logic                           in_tuser;   // operation
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tbq_pkg::DATA_W-1:0]     out_tdata;  // filtered_x, filtered_y, filtered_z
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tbq_pkg::REG_IDX_W-1:0]  cfg_index;
  logic [tbq_pkg::COEF_WIDTH-1:0] cfg_data;

  biquad_scoreboard sb = new();
  bit               in_gappy  = 1'b0;
  bit               out_gappy = 1'b1;
  int               results_seen = 0;

  three_axis_biquad_lowpass i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("three_axis_biquad_lowpass: mismatch");
    $finish;
  end

  function automatic tbq_pkg::sample_arr_t axes(tbq_pkg::sample_t x, tbq_pkg::sample_t y,
                                                tbq_pkg::sample_t z);
    tbq_pkg::sample_arr_t s;
    s[0] = x;
    s[1] = y;
    s[2] = z;
    return s;
  endfunction

  function automatic tbq_pkg::sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_TOP;
          1: return SAMPLE_BOTTOM;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return tbq_pkg::sample_t'($urandom);
      default: return tbq_pkg::sample_t'($signed($urandom_range(0, 32'h0020_0000))
                                         - 32'sh0010_0000);
    endcase
  endfunction

  function automatic void make_set(coef_kind_t kind, output tbq_pkg::coef_t c [tbq_pkg::REG_COUNT]);
    tbq_pkg::coef_t dflt [tbq_pkg::REG_COUNT];
    dflt = '{tbq_pkg::COEF_B0_RST, tbq_pkg::COEF_B1_RST, tbq_pkg::COEF_B2_RST,
             tbq_pkg::COEF_A1_RST, tbq_pkg::COEF_A2_RST};
    case (kind)
      SET_TOP:    foreach (c[i]) c[i] = COEF_TOP;
      SET_BOTTOM: foreach (c[i]) c[i] = COEF_BOTTOM;
      SET_UNITY: begin
        foreach (c[i]) c[i] = '0;
        c[tbq_pkg::REG_B0] = tbq_pkg::coef_t'(1 << tbq_pkg::FRAC_SHIFT);
      end
      SET_NEAR:   foreach (c[i]) c[i] = dflt[i]
                    + tbq_pkg::coef_t'($signed($urandom_range(0, 65536)) - 32768);
      SET_WILD:   foreach (c[i]) c[i] = tbq_pkg::coef_t'($urandom);
      default:    c = dflt;
    endcase
  endfunction

  task automatic send_item(logic op, tbq_pkg::sample_arr_t s);
    int gap;
    gap = in_gappy ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= tbq_pkg::DATA_W'(s);
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, s);
    if ($urandom_range(0, 39) == 0) in_gappy = ~in_gappy;
  endtask

  task automatic write_coefs(tbq_pkg::coef_t c [tbq_pkg::REG_COUNT]);
    logic [tbq_pkg::REG_IDX_W-1:0] junk_idx;
    tbq_pkg::coef_t                junk_val;
    for (int i = 0; i < tbq_pkg::REG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= tbq_pkg::REG_IDX_W'(i);
      cfg_data  <= c[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_coef(tbq_pkg::REG_IDX_W'(i), c[i]);
    end
    // unused index, must leave the set untouched
    junk_idx = tbq_pkg::REG_IDX_W'($urandom_range(tbq_pkg::REG_COUNT,
                                                  (1 << tbq_pkg::REG_IDX_W) - 1));
    junk_val = tbq_pkg::coef_t'($urandom);
    cfg_index <= junk_idx;
    cfg_data  <= junk_val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_coef(junk_idx, junk_val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (sb.filtered_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side, with one long hold-off to back the block up
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = out_gappy ? $urandom_range(0, 19) : 0;
      if (!held && results_seen >= HOLD_AFTER) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(tbq_pkg::sample_arr_t'(
        out_tdata[tbq_pkg::AXIS_COUNT*tbq_pkg::SAMPLE_WIDTH-1:0]));
      results_seen++;
      if ($urandom_range(0, 39) == 0) out_gappy = ~out_gappy;
    end
  end

  initial begin
    tbq_pkg::coef_t       c [tbq_pkg::REG_COUNT];
    coef_kind_t           plan [7];
    tbq_pkg::sample_arr_t s;
    logic                 op;
    int                   guard;
    plan = '{SET_TOP, SET_UNITY, SET_BOTTOM, SET_WILD, SET_NEAR, SET_WILD, SET_DEFAULT};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= tbq_pkg::OP_FILTER;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tbq_pkg::REG_B0;
    cfg_data  <= '0;
    sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero state, step overshoot into saturation, preload steady state
    send_item(tbq_pkg::OP_FILTER, axes('0, '0, '0));
    send_item(tbq_pkg::OP_FILTER, axes(SAMPLE_TOP, SAMPLE_BOTTOM, '1));
    send_item(tbq_pkg::OP_PRELOAD, axes(SAMPLE_BOTTOM, SAMPLE_TOP, 32'sd1));
    repeat (12) send_item(tbq_pkg::OP_FILTER, axes(SAMPLE_TOP, SAMPLE_BOTTOM, 32'sd1));
    send_item(tbq_pkg::OP_PRELOAD, axes(SAMPLE_TOP, SAMPLE_BOTTOM, '1));
    send_item(tbq_pkg::OP_FILTER, axes(SAMPLE_TOP, SAMPLE_BOTTOM, '1));
    send_item(tbq_pkg::OP_FILTER, axes(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000));
    send_item(tbq_pkg::OP_FILTER, axes(32'shAAAA_AAAA, 32'sh5555_5555, -32'sh0001_0000));
    in_tvalid <= 1'b0;
    wait_idle();

    foreach (plan[p]) begin
      make_set(plan[p], c);
      write_coefs(c);
      repeat (ITEMS_PER_SET) begin
        op = ($urandom_range(0, 9) == 0) ? tbq_pkg::OP_PRELOAD : tbq_pkg::OP_FILTER;
        s  = axes(rand_sample(), rand_sample(), rand_sample());
        send_item(op, s);
      end
      in_tvalid <= 1'b0;
      if (p != $size(plan) - 1) wait_idle();
    end

    guard = 0;
    while (sb.filtered_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.filtered_q.size() != 0) begin
      $error("%0d results never arrived", sb.filtered_q.size());
      sb.errors += sb.filtered_q.size();
    end
    if (sb.errors == 0) begin
      $display("three_axis_biquad_lowpass: match");
    end else begin
      $display("three_axis_biquad_lowpass: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tbq_pkg.sv
src/tbq_lane.sv
src/tbq_merge.sv
src/three_axis_biquad_lowpass.sv
test/three_axis_biquad_lowpass_tb.sv
